### src/rsg_pkg.sv
// shared types and constants for the refractory spike generator
package rsg_pkg;

    localparam int FIBRES_DEF = 16;
    localparam int FIBRE_W    = 4;
    localparam int TIMER_W    = 20;
    localparam int PULSE_W    = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int MUL_W      = 31;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int X_W        = 36;
    localparam int XS_W       = 20;
    localparam int P_W        = 17;

    localparam logic [TIMER_W-1:0] TIMER_MAX    = 20'hFFFFF;
    localparam logic [CFG_W-1:0]   REFR_RST     = 16'd75;
    localparam logic [CFG_W-1:0]   RATE_RST     = 16'd819;
    localparam logic [PULSE_W-1:0] PTICKS_RST   = 8'd1;
    localparam logic [CFG_W-1:0]   PMAG_RST     = 16'd256;
    localparam logic [TIMER_W-1:0] TIMER_RST    = 20'd76;
    localparam logic [MUL_W-1:0]   Q30_ONE      = 31'd1073741824;
    localparam logic [MUL_W-1:0]   EXP_SEED     = 31'd1073725440;
    localparam logic [PROD_W:0]    Q30_HALF     = 63'd536870912;
    localparam logic [MUL_W:0]     Q14_HALF     = 32'd8192;
    localparam logic [P_W:0]       Q16_ONE_WIDE = 18'h10000;
    localparam logic [P_W-1:0]     Q16_ONE      = 17'h10000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_REFRACTORY  = 2'd0,
        REG_RATE        = 2'd1,
        REG_PULSE_TICKS = 2'd2,
        REG_PULSE_MAG   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SCALE,
        ST_EXP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TIMER_W-1:0] timer;
        logic [PULSE_W-1:0] pulse_left;
    } t_fibre_ent;

endpackage

### src/refractory_spike_generator_unit.sv
// top level of the refractory spike generator with iterative exp sequencer
// sequence: accept, load, then scale and exp iterations when the fibre may fire, done;
//   the result is registered into the output slot once it is free
// requests: one at a time; ready only in idle, after the previous result is registered
// reset: synchronous active low; a clearing pass then loads every
//   fibre entry, and no request is taken until it ends
module refractory_spike_generator_unit #(
    parameter int FIBRES = rsg_pkg::FIBRES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [rsg_pkg::FIBRE_W-1:0]       i_fibre,
    input  logic                              i_release_req,
    input  logic [rsg_pkg::CFG_W-1:0]         i_random_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rsg_pkg::FIBRE_W-1:0]       o_fibre_out,
    output logic                              o_spike,
    output logic [rsg_pkg::CFG_W-1:0]         o_pulse_out,
    input  logic                              i_cfg_we,
    input  logic [rsg_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [rsg_pkg::CFG_W-1:0]         i_cfg_wdata
);

    localparam int IDX_W = (FIBRES > 1) ? $clog2(FIBRES) : 1;
    localparam int RNG_W = 11;
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(FIBRES - 1);

    rsg_pkg::t_state r_state, n_state;

    // configuration
    logic [rsg_pkg::CFG_W-1:0]   r_refr;
    logic [rsg_pkg::CFG_W-1:0]   r_rate;
    logic [rsg_pkg::PULSE_W-1:0] r_pulse_ticks;
    logic [rsg_pkg::CFG_W-1:0]   r_pulse_mag;

    // fibre state memory
    rsg_pkg::t_fibre_ent r_mem [FIBRES];
    rsg_pkg::t_fibre_ent r_rd;
    rsg_pkg::t_fibre_ent w_wr_data;
    logic [IDX_W-1:0]    w_wr_idx;
    logic [IDX_W-1:0]    w_in_idx;
    logic [IDX_W+rsg_pkg::FIBRE_W-1:0] w_fibre_wide;
    logic [IDX_W-1:0]    r_clr_idx;

    // request registers
    logic [rsg_pkg::FIBRE_W-1:0] r_fibre;
    logic                        r_release;
    logic [rsg_pkg::CFG_W-1:0]   r_rnd;
    logic                        r_in_range;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_run;
    logic [rsg_pkg::TIMER_W-1:0] r_excess;

    // exp iteration
    logic [rsg_pkg::XS_W-1:0]    r_xs;
    logic                        r_big;
    logic [rsg_pkg::MUL_W-1:0]   r_e;
    logic [rsg_pkg::MUL_W-1:0]   r_f;
    logic                        r_phase;

    // output register
    logic                        r_out_valid;
    logic [rsg_pkg::FIBRE_W-1:0] r_out_fibre;
    logic                        r_out_spike;
    logic [rsg_pkg::CFG_W-1:0]   r_out_pulse;

    // control
    logic w_accept;
    logic w_slot_free;
    logic w_run;
    logic w_exp_end;
    logic w_mul_ef;
    logic c_mem_we;
    logic c_ld_out;

    // shared multiplier
    logic [rsg_pkg::MUL_W-1:0]  w_mul_a;
    logic [rsg_pkg::MUL_W-1:0]  w_mul_b;
    logic [rsg_pkg::PROD_W-1:0] w_prod;
    logic [rsg_pkg::MUL_W-1:0]  w_round;

    // result datapath
    logic [rsg_pkg::MUL_W:0]     w_e_sum;
    logic [rsg_pkg::P_W:0]       w_e16;
    logic [rsg_pkg::P_W:0]       w_e16_sat;
    logic [rsg_pkg::P_W-1:0]     w_p;
    logic                        w_spike;
    logic [rsg_pkg::PULSE_W-1:0] w_pl;
    logic                        w_pulse_on;
    logic [rsg_pkg::PULSE_W-1:0] w_pl_next;
    logic [rsg_pkg::TIMER_W-1:0] w_t;
    logic [rsg_pkg::TIMER_W-1:0] w_t_next;

    rsg_mul_unit u_mul (
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_prod  (w_prod),
        .o_round (w_round)
    );

    assign w_fibre_wide = {{IDX_W{1'b0}}, i_fibre};
    assign w_in_idx     = w_fibre_wide[IDX_W-1:0];
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign w_run        = r_in_range && r_release &&
                          (r_rd.timer > {4'b0, r_refr});
    assign w_exp_end    = r_big || (r_xs == '0);
    assign w_mul_ef     = r_xs[0] && !r_phase;

    // probability and state update
    assign w_e_sum   = {1'b0, r_e} + rsg_pkg::Q14_HALF;
    assign w_e16     = w_e_sum[14 +: rsg_pkg::P_W + 1];
    assign w_e16_sat = (w_e16 > rsg_pkg::Q16_ONE_WIDE) ? rsg_pkg::Q16_ONE_WIDE : w_e16;
    always_comb begin
        if (r_big) begin
            w_p = rsg_pkg::Q16_ONE;
        end else begin
            w_p = rsg_pkg::P_W'(rsg_pkg::Q16_ONE_WIDE - w_e16_sat);
        end
    end
    assign w_spike    = r_run && (w_p > {1'b0, r_rnd});
    always_comb begin
        if (w_spike) begin
            w_pl = (r_pulse_ticks == '0) ? 8'd1 : r_pulse_ticks;
        end else begin
            w_pl = r_rd.pulse_left;
        end
    end
    assign w_pulse_on = r_in_range && (w_pl != '0);
    assign w_pl_next  = w_pulse_on ? (w_pl - 8'd1) : w_pl;
    assign w_t        = w_spike ? '0 : r_rd.timer;
    assign w_t_next   = (w_t != rsg_pkg::TIMER_MAX) ? (w_t + 20'd1) : w_t;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsg_pkg::ST_CLEAR: begin
                if (r_clr_idx == CLR_LAST) n_state = rsg_pkg::ST_IDLE;
            end
            rsg_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = rsg_pkg::ST_LOAD;
            end
            rsg_pkg::ST_LOAD: begin
                n_state = w_run ? rsg_pkg::ST_SCALE : rsg_pkg::ST_DONE;
            end
            rsg_pkg::ST_SCALE: begin
                n_state = rsg_pkg::ST_EXP;
            end
            rsg_pkg::ST_EXP: begin
                if (w_exp_end) n_state = rsg_pkg::ST_DONE;
            end
            rsg_pkg::ST_DONE: begin
                if (w_slot_free) n_state = rsg_pkg::ST_IDLE;
            end
            default: begin
                n_state = rsg_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        c_mem_we   = 1'b0;
        c_ld_out   = 1'b0;
        w_mul_a    = r_f;
        w_mul_b    = r_f;
        w_wr_idx   = r_idx;
        w_wr_data  = '{timer: w_t_next, pulse_left: w_pl_next};
        case (r_state)
            rsg_pkg::ST_CLEAR: begin
                c_mem_we  = 1'b1;
                w_wr_idx  = r_clr_idx;
                w_wr_data = '{timer: rsg_pkg::TIMER_RST, pulse_left: '0};
            end
            rsg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            rsg_pkg::ST_SCALE: begin
                w_mul_a = {11'b0, r_excess};
                w_mul_b = {15'b0, r_rate};
            end
            rsg_pkg::ST_EXP: begin
                w_mul_a = w_mul_ef ? r_e : r_f;
            end
            rsg_pkg::ST_DONE: begin
                c_mem_we = w_slot_free && r_in_range;
                c_ld_out = w_slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rsg_pkg::ST_CLEAR;
            r_clr_idx     <= '0;
            r_out_valid   <= 1'b0;
            r_refr        <= rsg_pkg::REFR_RST;
            r_rate        <= rsg_pkg::RATE_RST;
            r_pulse_ticks <= rsg_pkg::PTICKS_RST;
            r_pulse_mag   <= rsg_pkg::PMAG_RST;
        end else begin
            r_state <= n_state;
            if (r_state == rsg_pkg::ST_CLEAR) r_clr_idx <= r_clr_idx + 1'b1;
            if (c_ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (rsg_pkg::t_reg_idx'(i_cfg_addr))
                    rsg_pkg::REG_REFRACTORY:  r_refr        <= i_cfg_wdata;
                    rsg_pkg::REG_RATE:        r_rate        <= i_cfg_wdata;
                    rsg_pkg::REG_PULSE_TICKS: r_pulse_ticks <= i_cfg_wdata[7:0];
                    rsg_pkg::REG_PULSE_MAG:   r_pulse_mag   <= i_cfg_wdata;
                    default:                  r_refr        <= r_refr;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fibre    <= i_fibre;
            r_release  <= i_release_req;
            r_rnd      <= i_random_value;
            r_in_range <= ({7'b0, i_fibre} < RNG_W'(FIBRES));
            r_idx      <= w_in_idx;
        end
        if (r_state == rsg_pkg::ST_LOAD) begin
            r_run    <= w_run;
            r_excess <= r_rd.timer - {4'b0, r_refr};
        end
        if (r_state == rsg_pkg::ST_SCALE) begin
            r_xs    <= w_prod[rsg_pkg::XS_W-1:0];
            r_big   <= |w_prod[rsg_pkg::X_W-1:rsg_pkg::XS_W];
            r_e     <= rsg_pkg::Q30_ONE;
            r_f     <= rsg_pkg::EXP_SEED;
            r_phase <= 1'b0;
        end
        if ((r_state == rsg_pkg::ST_EXP) && !w_exp_end) begin
            if (w_mul_ef) begin
                r_e     <= w_round;
                r_phase <= 1'b1;
            end else begin
                r_f     <= w_round;
                r_xs    <= r_xs >> 1;
                r_phase <= 1'b0;
            end
        end
        if (c_ld_out) begin
            r_out_fibre <= r_fibre;
            r_out_spike <= w_spike;
            r_out_pulse <= w_pulse_on ? r_pulse_mag : '0;
        end
    end

    // fibre memory
    always_ff @(posedge i_clk) begin
        if (c_mem_we) r_mem[w_wr_idx] <= w_wr_data;
        if (w_accept) r_rd <= r_mem[w_in_idx];
    end

    assign o_out_valid = r_out_valid;
    assign o_fibre_out = r_out_fibre;
    assign o_spike     = r_out_spike;
    assign o_pulse_out = r_out_pulse;

`ifndef SYNTHESIS
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == rsg_pkg::ST_LOAD))
        else $error("accepted request did not start a load");

    a_done_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsg_pkg::ST_DONE) |=> ((r_state == rsg_pkg::ST_DONE) || o_out_valid))
        else $error("done state left without a result");

    a_spike_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_spike) |-> (o_pulse_out == r_pulse_mag))
        else $error("spike without pulse magnitude");

    a_exp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsg_pkg::ST_EXP) |-> ((r_e <= rsg_pkg::Q30_ONE) &&
                                          (r_f <= rsg_pkg::EXP_SEED)))
        else $error("exp iteration out of range");

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rsg_pkg::ST_EXP) || (r_state == rsg_pkg::ST_CLEAR)) |-> !o_in_ready)
        else $error("ready while busy");
`endif

endmodule

### src/rsg_mul_unit.sv
// shared multiplier with q0.30 rounding of the product
module rsg_mul_unit (
    input  logic [rsg_pkg::MUL_W-1:0]  i_a,
    input  logic [rsg_pkg::MUL_W-1:0]  i_b,
    output logic [rsg_pkg::PROD_W-1:0] o_prod,
    output logic [rsg_pkg::MUL_W-1:0]  o_round
);

    logic [rsg_pkg::PROD_W:0] w_sum;

    assign o_prod  = i_a * i_b;
    assign w_sum   = {1'b0, o_prod} + rsg_pkg::Q30_HALF;
    assign o_round = w_sum[30 +: rsg_pkg::MUL_W];

endmodule

### tb/sv/rsg_tick_checker.sv
// request and result checker for the refractory spike generator
module rsg_tick_checker
    import rsg_pkg::*;
#(
    parameter int FIBRES = FIBRES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [FIBRE_W-1:0]    i_fibre,
    input  logic                  i_release_req,
    input  logic [CFG_W-1:0]      i_random_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [FIBRE_W-1:0]    i_fibre_out,
    input  logic                  i_spike,
    input  logic [CFG_W-1:0]      i_pulse_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    output int unsigned           o_mismatches,
    output int unsigned           o_outstanding
);

    typedef struct packed {
        logic [FIBRE_W-1:0] fibre;
        logic               spike;
        logic [CFG_W-1:0]   pulse;
    } t_tick_result;

    logic [CFG_W-1:0]   refractory = REFR_RST;
    logic [CFG_W-1:0]   recovery   = RATE_RST;
    logic [PULSE_W-1:0] pulse_len  = PTICKS_RST;
    logic [CFG_W-1:0]   magnitude  = PMAG_RST;

    logic [TIMER_W-1:0] tick_age     [FIBRES];
    logic [PULSE_W-1:0] pulse_remain [FIBRES];

    t_tick_result expected_ticks [$];
    int unsigned  mismatch_count = 0;

    initial o_outstanding = 0;
    assign o_mismatches = mismatch_count;

    // 1 - exp(-excess * rate / 2^16) in Q0.16, exp built from squared Q0.30 factors
    function automatic logic [P_W-1:0] spike_chance(input logic [TIMER_W-1:0] excess,
                                                     input logic [CFG_W-1:0] rate);
        logic [63:0] x;
        logic [63:0] e;
        logic [63:0] f;
        x = 64'(excess) * 64'(rate);
        if (x[63:20] != '0)
            return Q16_ONE;
        e = 64'(Q30_ONE);
        f = 64'(EXP_SEED);
        for (int k = 0; k < 20; k++) begin
            if (x[k])
                e = (e * f + 64'(Q30_HALF)) >> 30;
            f = (f * f + 64'(Q30_HALF)) >> 30;
        end
        e = (e + 64'd8192) >> 14;
        if (e > 64'd65536)
            e = 64'd65536;
        return P_W'(64'd65536 - e);
    endfunction

    function automatic t_tick_result predict_tick(input logic [FIBRE_W-1:0] fib,
                                                  input logic rel,
                                                  input logic [CFG_W-1:0] rnd);
        t_tick_result r;
        logic [TIMER_W-1:0] age;
        r.fibre = fib;
        r.spike = 1'b0;
        r.pulse = '0;
        if (int'(fib) < FIBRES) begin
            age = tick_age[fib];
            if (rel && age > TIMER_W'(refractory)) begin
                if (spike_chance(age - TIMER_W'(refractory), recovery) > P_W'(rnd)) begin
                    r.spike = 1'b1;
                    age = '0;
                    pulse_remain[fib] = (pulse_len == '0) ? PULSE_W'(1) : pulse_len;
                end
            end
            if (pulse_remain[fib] != '0) begin
                r.pulse = magnitude;
                pulse_remain[fib] = pulse_remain[fib] - 1'b1;
            end
            if (age != TIMER_MAX)
                age = age + 1'b1;
            tick_age[fib] = age;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_tick_result want;
        if (!i_rst_n) begin
            refractory = REFR_RST;
            recovery   = RATE_RST;
            pulse_len  = PTICKS_RST;
            magnitude  = PMAG_RST;
            for (int i = 0; i < FIBRES; i++) begin
                tick_age[i]     = TIMER_RST;
                pulse_remain[i] = '0;
            end
            expected_ticks.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: unexpected result fibre %0d spike %0d pulse %0d",
                             $time, i_fibre_out, i_spike, i_pulse_out);
                    mismatch_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (i_fibre_out !== want.fibre) begin
                        $display("%0t: fibre_out expected %0d actual %0d",
                                 $time, want.fibre, i_fibre_out);
                        mismatch_count++;
                    end
                    if (i_spike !== want.spike) begin
                        $display("%0t: spike expected %0d actual %0d (fibre %0d)",
                                 $time, want.spike, i_spike, want.fibre);
                        mismatch_count++;
                    end
                    if (i_pulse_out !== want.pulse) begin
                        $display("%0t: pulse_out expected %0d actual %0d (fibre %0d)",
                                 $time, want.pulse, i_pulse_out, want.fibre);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_REFRACTORY:  refractory = i_cfg_wdata;
                    REG_RATE:        recovery   = i_cfg_wdata;
                    REG_PULSE_TICKS: pulse_len  = i_cfg_wdata[PULSE_W-1:0];
                    REG_PULSE_MAG:   magnitude  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_ticks.push_back(predict_tick(i_fibre, i_release_req, i_random_value));
        end
        o_outstanding <= expected_ticks.size();
    end

endmodule

### tb/sv/tb_top.sv
// testbench top: drives fibre ticks and register writes, gives the verdict
module tb_top;
    import rsg_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [FIBRE_W-1:0]    i_fibre        = '0;
    logic                  i_release_req  = 1'b0;
    logic [CFG_W-1:0]      i_random_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [FIBRE_W-1:0]    o_fibre_out;
    logic                  o_spike;
    logic [CFG_W-1:0]      o_pulse_out;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr     = '0;
    logic [CFG_W-1:0]      i_cfg_wdata    = '0;

    logic        calm   = 1'b0;
    int unsigned sent   = 0;
    int unsigned cycles = 0;
    int unsigned phase  = 0;
    int unsigned burst  = 0;
    int unsigned mismatches;
    int unsigned outstanding;

    refractory_spike_generator_unit dut (.*);

    rsg_tick_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_fibre        (i_fibre),
        .i_release_req  (i_release_req),
        .i_random_value (i_random_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_fibre_out    (o_fibre_out),
        .i_spike        (o_spike),
        .i_pulse_out    (o_pulse_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_tick(input logic [FIBRE_W-1:0] fib, input logic rel,
                             input logic [CFG_W-1:0] rnd);
        if (!calm && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 40);
        end
        i_in_valid     <= 1'b1;
        i_fibre        <= fib;
        i_release_req  <= rel;
        i_random_value <= rnd;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] refr, input logic [CFG_W-1:0] rate,
                              input logic [PULSE_W-1:0] pticks,
                              input logic [CFG_W-1:0] pmag);
        drain();
        write_reg(REG_REFRACTORY, refr);
        write_reg(REG_RATE, rate);
        write_reg(REG_PULSE_TICKS, CFG_W'(pticks));
        write_reg(REG_PULSE_MAG, pmag);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned count);
        logic [CFG_W-1:0]   refr;
        logic [CFG_W-1:0]   rate;
        logic [CFG_W-1:0]   rnd;
        logic [PULSE_W-1:0] pticks;
        logic [FIBRE_W-1:0] mask;
        int unsigned        span;
        int unsigned        pick;
        refr = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 10));
        case ($urandom_range(0, 3))
            0:       rate = CFG_W'($urandom_range(0, 64));
            1:       rate = CFG_W'($urandom_range(0, 2000));
            default: rate = CFG_W'($urandom);
        endcase
        pticks = ($urandom_range(0, 4) == 0) ? PULSE_W'($urandom) : PULSE_W'($urandom_range(0, 5));
        span   = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 4);
        mask   = FIBRE_W'($urandom);
        set_config(refr, rate, pticks, CFG_W'($urandom));
        repeat (count) begin
            pick = $urandom_range(0, 9);
            rnd  = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : CFG_W'($urandom);
            send_tick(FIBRE_W'($urandom_range(0, span - 1)) ^ mask,
                      $urandom_range(0, 99) < 85, rnd);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one tick past refractory, tiny probability
        send_tick(4'd0, 1'b0, 16'h0000);
        send_tick(4'd3, 1'b1, 16'h0000);
        send_tick(4'd3, 1'b1, 16'h0000);
        send_tick(4'd15, 1'b1, 16'hFFFF);
        send_tick(4'd9, 1'b1, 16'h8000);

        // max rate and zero pulse length: large exponent always fires
        set_config(16'd0, 16'hFFFF, 8'd0, 16'hFFFF);
        send_tick(4'd15, 1'b1, 16'hFFFF);
        send_tick(4'd15, 1'b1, 16'hFFFF);
        send_tick(4'd15, 1'b1, 16'h0000);
        send_tick(4'd5, 1'b0, 16'h0000);
        send_tick(4'd10, 1'b1, 16'h1234);

        // zero rate never fires
        set_config(16'd0, 16'd0, 8'd255, 16'd0);
        send_tick(4'd1, 1'b1, 16'h0000);
        send_tick(4'd1, 1'b1, 16'h0000);

        // refractory at its maximum
        set_config(16'hFFFF, 16'd1, 8'd255, 16'h5A5A);
        send_tick(4'd2, 1'b1, 16'h0000);
        send_tick(4'd12, 1'b1, 16'h0000);

        // long pulse keeps running across ticks without release
        set_config(16'd0, 16'h8000, 8'd255, 16'hA5A5);
        send_tick(4'd6, 1'b1, 16'h0000);
        send_tick(4'd6, 1'b0, 16'hFFFF);
        send_tick(4'd6, 1'b1, 16'hFFFF);
        send_tick(4'd6, 1'b0, 16'h0000);

        set_config(16'd1, 16'd100, 8'd3, 16'h0100);
        send_tick(4'd7, 1'b1, 16'h0000);
        send_tick(4'd7, 1'b1, 16'h0001);
        send_tick(4'd7, 1'b1, 16'h0000);
        send_tick(4'd8, 1'b1, 16'h7FFF);

        while (sent < ITEM_TARGET) begin
            calm <= (phase == 2);
            burst = $urandom_range(100, 200);
            if (burst > ITEM_TARGET - sent)
                burst = ITEM_TARGET - sent;
            random_phase(burst);
            phase++;
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
src/rsg_pkg.sv
src/rsg_mul_unit.sv
src/refractory_spike_generator_unit.sv
tb/sv/rsg_tick_checker.sv
tb/sv/tb_top.sv
